/* design/pact_pkg.sv */
// shared types and constants of the page access count table
`default_nettype none

package pact_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned PAGE_W   = 36;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned USED_W   = 7;
  localparam int unsigned STATUS_W = 2;

  // request kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_IGNORE = 2'd2
  } cmd_op_e;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  address;
    logic [SIZE_W-1:0]  access_size;
    logic [PAGE_W-1:0]  query_page;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  page_count;
    logic [PAGE_W-1:0]   lowest_page;
    logic [PAGE_W-1:0]   highest_page;
    logic [USED_W-1:0]   entries_used;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // classified work handed from front to back
  typedef struct packed {
    cmd_op_e           op;
    logic [PAGE_W-1:0] first_page;
    logic [PAGE_W-1:0] last_page;
  } cmd_t;

  // table state seen by the front
  typedef struct packed {
    logic full;
  } tbl_stat_t;

endpackage

`default_nettype wire

/* design/pact_front.sv */
// front end: latches a request and turns it into a table command
`default_nettype none

module pact_front #(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire pact_pkg::req_t    req_i,
  input  wire pact_pkg::tbl_stat_t stat_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output pact_pkg::cmd_t         cmd_o
);

  localparam int unsigned SUM_W = pact_pkg::ADDR_W + 1;

  pact_pkg::req_t   req_q;
  logic             hold_q, hold_d;
  logic [SUM_W-1:0] last_byte;
  logic [SUM_W-1:0] last_shift;
  logic [pact_pkg::ADDR_W-1:0] first_shift;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  // last byte touched, one wide add; size is nonzero when used
  always_comb begin
    last_byte   = {1'b0, req_q.address} + SUM_W'(req_q.access_size) - SUM_W'(1);
    last_shift  = last_byte >> PAGE_SHIFT;
    first_shift = req_q.address >> PAGE_SHIFT;
  end

  always_comb begin
    cmd_o.first_page = first_shift[pact_pkg::PAGE_W-1:0];
    cmd_o.last_page  = last_shift[pact_pkg::PAGE_W-1:0];
    if (req_q.kind == pact_pkg::KIND_QUERY) begin
      cmd_o.op         = pact_pkg::CMD_QUERY;
      cmd_o.first_page = req_q.query_page;
      cmd_o.last_page  = req_q.query_page;
    end else if (req_q.access_size == '0 || stat_i.full) begin
      cmd_o.op = pact_pkg::CMD_IGNORE;
    end else begin
      cmd_o.op = pact_pkg::CMD_RECORD;
    end
  end

  assign push_o = hold_q && !q_full_i;

  always_comb begin
    hold_d = hold_q;
    if (push_o) begin
      hold_d = 1'b0;
    end
    if (accept_i) begin
      hold_d = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* design/pact_queue.sv */
// two entry command queue between front and back
`default_nettype none

module pact_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pact_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output logic                vld_o,
  output logic                full_o,
  output pact_pkg::cmd_t      cmd_o
);

  pact_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign vld_o   = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/pact_back.sv */
// back end: scans the page table, updates counters and builds results
`default_nettype none

module pact_back #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_vld_i,
  input  wire pact_pkg::cmd_t    q_cmd_i,
  output logic                   pop_o,
  output pact_pkg::tbl_stat_t    stat_o,
  output logic                   rsp_valid_o,
  output pact_pkg::rsp_t         rsp_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned TOT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EXT_W = (TOT_W > pact_pkg::USED_W) ? TOT_W : pact_pkg::USED_W;
  localparam logic [TOT_W-1:0] TOT_MAX = TOT_W'(TABLE_ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // table memories
  logic [pact_pkg::PAGE_W-1:0]  key_mem [TABLE_ENTRIES];
  logic [pact_pkg::COUNT_W-1:0] cnt_mem [TABLE_ENTRIES];
  logic [pact_pkg::PAGE_W-1:0]  key_rd_q;
  logic [pact_pkg::COUNT_W-1:0] cnt_rd_q;

  logic                          rd_en;
  logic                          wr_key_en, wr_cnt_en;
  logic [IDX_W-1:0]              wr_idx;
  logic [pact_pkg::COUNT_W-1:0]  wr_cnt;

  logic                          state_q, state_d;
  pact_pkg::cmd_t                cmd_q, cmd_d;
  logic [pact_pkg::PAGE_W-1:0]   page_q, page_d;
  logic [TOT_W-1:0]              rd_idx_q, rd_idx_d;
  logic                          pend_q, pend_d;
  logic [IDX_W-1:0]              pend_idx_q, pend_idx_d;
  logic [TOT_W-1:0]              total_q, total_d;
  logic [pact_pkg::PAGE_W-1:0]   min_q, min_d, max_q, max_d;
  logic [pact_pkg::STATUS_W-1:0] status_q, status_d;
  logic [pact_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                          rsp_valid_q, rsp_valid_d;
  pact_pkg::rsp_t                rsp_q, rsp_d;

  logic             hit, miss, page_done, emit;
  logic [EXT_W-1:0] total_ext;

  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_idx] <= page_q;
    end
    if (wr_cnt_en) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_idx_q[IDX_W-1:0]];
      cnt_rd_q <= cnt_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    page_q     <= page_d;
    pend_idx_q <= pend_idx_d;
    count_q    <= count_d;
    status_q   <= status_d;
    rd_idx_q   <= rd_idx_d;
    rsp_q      <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      total_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      total_q     <= total_d;
      min_q       <= min_d;
      max_q       <= max_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign hit  = pend_q && (key_rd_q == page_q);
  assign miss = !pend_q && (rd_idx_q >= total_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    page_d      = page_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    total_d     = total_q;
    min_d       = min_q;
    max_d       = max_q;
    status_d    = status_q;
    count_d     = count_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    wr_key_en   = 1'b0;
    wr_cnt_en   = 1'b0;
    wr_idx      = pend_idx_q;
    wr_cnt      = '0;
    page_done   = 1'b0;
    emit        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_vld_i) begin
          pop_o    = 1'b1;
          cmd_d    = q_cmd_i;
          page_d   = q_cmd_i.first_page;
          rd_idx_d = '0;
          pend_d   = 1'b0;
          count_d  = '0;
          status_d = pact_pkg::STATUS_OK;
          if (q_cmd_i.op == pact_pkg::CMD_IGNORE) begin
            status_d = pact_pkg::STATUS_IGNORED;
            emit     = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (cmd_q.op == pact_pkg::CMD_QUERY) begin
            count_d = cnt_rd_q;
            emit    = 1'b1;
          end else begin
            // saturating bump of a tracked page
            wr_cnt_en = 1'b1;
            wr_cnt    = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + pact_pkg::COUNT_W'(1);
            page_done = 1'b1;
          end
        end else if (miss) begin
          if (cmd_q.op == pact_pkg::CMD_QUERY) begin
            emit = 1'b1;
          end else begin
            if (total_q < TOT_MAX) begin
              // entries fill in order, so the next free slot is the count
              wr_key_en = 1'b1;
              wr_cnt_en = 1'b1;
              wr_idx    = total_q[IDX_W-1:0];
              wr_cnt    = pact_pkg::COUNT_W'(1);
              total_d   = total_q + TOT_W'(1);
              if (total_q == '0) begin
                min_d = page_q;
                max_d = page_q;
              end else begin
                if (page_q < min_q) begin
                  min_d = page_q;
                end
                if (page_q > max_q) begin
                  max_d = page_q;
                end
              end
            end else begin
              status_d = pact_pkg::STATUS_DROPPED;
            end
            page_done = 1'b1;
          end
        end else begin
          if (rd_idx_q < total_q) begin
            rd_en      = 1'b1;
            pend_d     = 1'b1;
            pend_idx_d = rd_idx_q[IDX_W-1:0];
            rd_idx_d   = rd_idx_q + TOT_W'(1);
          end else begin
            pend_d = 1'b0;
          end
        end

        if (page_done) begin
          if (page_q == cmd_q.last_page) begin
            emit = 1'b1;
          end else begin
            page_d   = page_q + pact_pkg::PAGE_W'(1);
            rd_idx_d = '0;
            pend_d   = 1'b0;
          end
        end
        if (emit) begin
          state_d = ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    total_ext = EXT_W'(total_d);
    if (emit) begin
      rsp_valid_d        = 1'b1;
      rsp_d.page_count   = count_d;
      rsp_d.lowest_page  = min_d;
      rsp_d.highest_page = max_d;
      rsp_d.entries_used = total_ext[pact_pkg::USED_W-1:0];
      rsp_d.status       = status_d;
    end
  end

  assign stat_o.full  = total_q >= TOT_MAX;
  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_o        = rsp_q;

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOT_MAX)
    else $error("entry count beyond table size");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_q == $past(total_q)) || (total_q == $past(total_q) + TOT_W'(1)))
    else $error("entry count moved by more than one");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) |-> (min_q <= max_q))
    else $error("lowest page above highest page");

  a_pend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (TOT_W'(pend_idx_q) < total_q))
    else $error("pending read of an unused entry");

  a_rsp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |=> !rsp_valid_q)
    else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

/* design/page_access_count_table_unit.sv */
// top level of the page access count table
//
//  channel   | handshake          | payload                      | direction
//  ----------+--------------------+------------------------------+----------
//  request   | start / busy       | req_i  (pact_pkg::req_t)     | in
//  result    | rsp_valid_o strobe | rsp_o  (pact_pkg::rsp_t)     | out
//
// one request in flight: busy is high from acceptance through its result
// strobe, and the next request can be taken in the cycle after that strobe
// from acceptance to result: the front latches the request, the queue holds it,
// the back scans the table for each page, one entry per cycle through one key
// comparator, and registers the result; 1 page for a query, up to 17 for a record
// with 4 KiB pages, and no scan at all for an ignored record
// reset clears the entry count, lowest and highest page and control, not the
// memories, since only entries below the count are ever read
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module page_access_count_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PAGE_SHIFT    = 12
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire pact_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  output pact_pkg::rsp_t       rsp_o
);

  logic                accept;
  logic                busy_q;
  logic                push;
  pact_pkg::cmd_t      front_cmd;
  logic                q_vld, q_full, pop;
  pact_pkg::cmd_t      q_cmd;
  pact_pkg::tbl_stat_t tbl_stat;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // busy covers the request from acceptance until its result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (rsp_valid_o) begin
      busy_q <= 1'b0;
    end
  end

  // front: latch and classify (query, record, or ignored record)
  pact_front #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .stat_i   (tbl_stat),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  // short command queue decoupling classification from the table scan
  pact_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .vld_o  (q_vld),
    .full_o (q_full),
    .cmd_o  (q_cmd)
  );

  // back: table scan, counter update, new entries and result register
  pact_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .stat_o      (tbl_stat),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_page_access_count_table_unit.sv */
// self-checking testbench for the page access count table unit
`default_nettype none

module tb_page_access_count_table_unit;
  import pact_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned PAGE_SHIFT    = 12;

  // pool of page regions that well-formed random accesses stay inside
  localparam int unsigned REGIONS      = 6;
  localparam int unsigned REGION_PAGES = 6;
  // noise accesses may open new pages only below this entry count
  localparam int unsigned NOISE_ROOM   = 58;
  // longest request: 17 pages scanning a full table, plus margin
  localparam int unsigned DRAIN_CYCLES = 1500;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  always #1 clk_i = ~clk_i;

  page_access_count_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // shadow copy of the page table, updated as each request is taken
  logic [PAGE_W-1:0]  tracked_key     [TABLE_ENTRIES];
  logic [COUNT_W-1:0] tracked_count   [TABLE_ENTRIES];
  bit                 tracked_valid   [TABLE_ENTRIES];
  int unsigned        tracked_total;
  logic [PAGE_W-1:0]  tracked_lowest;
  logic [PAGE_W-1:0]  tracked_highest;

  // results still owed by the block, oldest first
  rsp_t expected_rsp_q[$];
  rsp_t expected_rsp;
  int   mismatch_count = 0;

  // one in idle_odds requests is preceded by an idle burst; 0 means none
  int unsigned idle_odds = 0;

  logic [PAGE_W-1:0] region_base[REGIONS];

  // ---------------------------------------------------------------------------
  // table model
  // ---------------------------------------------------------------------------

  function automatic int find_tracked_page(logic [PAGE_W-1:0] page);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tracked_valid[i] && tracked_key[i] == page) return i;
    end
    return -1;
  endfunction

  // bumps one page, opening an entry if needed; 0 when no entry was free
  function automatic bit count_page(logic [PAGE_W-1:0] page);
    int slot;
    slot = find_tracked_page(page);
    if (slot >= 0) begin
      if (tracked_count[slot] != '1) tracked_count[slot] = tracked_count[slot] + 1'b1;
      return 1'b1;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tracked_valid[i]) begin
        tracked_valid[i] = 1'b1;
        tracked_key[i]   = page;
        tracked_count[i] = COUNT_W'(1);
        if (tracked_total == 0) begin
          tracked_lowest  = page;
          tracked_highest = page;
        end else begin
          if (page < tracked_lowest)  tracked_lowest  = page;
          if (page > tracked_highest) tracked_highest = page;
        end
        tracked_total++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t predict_table_access(req_t r);
    rsp_t              rsp;
    int                slot;
    logic [PAGE_W-1:0] page;
    int unsigned       offset;
    int unsigned       span;
    rsp = '0;
    if (r.kind == KIND_QUERY) begin
      slot = find_tracked_page(r.query_page);
      if (slot >= 0) rsp.page_count = tracked_count[slot];
    end else if (r.access_size == 0 || tracked_total >= TABLE_ENTRIES) begin
      rsp.status = STATUS_IGNORED;
    end else begin
      // span counts from the offset in the first page to the last byte
      page   = r.address[ADDR_W-1:PAGE_SHIFT];
      offset = 32'(r.address[PAGE_SHIFT-1:0]);
      span   = ((offset + r.access_size - 1) >> PAGE_SHIFT) + 1;
      rsp.status = STATUS_OK;
      for (int unsigned k = 0; k < span; k++) begin
        if (!count_page(page)) rsp.status = STATUS_DROPPED;
        page = page + 1'b1;  // wraps at the top of the page space
      end
    end
    rsp.lowest_page  = (tracked_total != 0) ? tracked_lowest  : '0;
    rsp.highest_page = (tracked_total != 0) ? tracked_highest : '0;
    rsp.entries_used = tracked_total[USED_W-1:0];
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders; fields a kind does not use are filled with noise
  // ---------------------------------------------------------------------------

  function automatic logic [ADDR_W-1:0] rand_address();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic [PAGE_W-1:0] rand_page();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[PAGE_W-1:0];
  endfunction

  function automatic req_t record_req(logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
    req_t r;
    r.kind        = KIND_RECORD;
    r.address     = addr;
    r.access_size = size;
    r.query_page  = rand_page();
    return r;
  endfunction

  function automatic req_t query_req(logic [PAGE_W-1:0] page);
    req_t r;
    r.kind        = KIND_QUERY;
    r.address     = rand_address();
    r.access_size = SIZE_W'($urandom());
    r.query_page  = page;
    return r;
  endfunction

  // some page that is in the table, or a random one when it is empty
  function automatic logic [PAGE_W-1:0] some_tracked_page();
    int unsigned first;
    if (tracked_total == 0) return rand_page();
    first = $urandom_range(0, TABLE_ENTRIES - 1);
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      if (tracked_valid[(first + i) % TABLE_ENTRIES])
        return tracked_key[(first + i) % TABLE_ENTRIES];
    end
    return rand_page();
  endfunction

  function automatic logic [PAGE_W-1:0] fresh_page();
    logic [PAGE_W-1:0] page;
    do page = rand_page(); while (find_tracked_page(page) >= 0);
    return page;
  endfunction

  // an access whose pages all lie inside one pool region
  function automatic req_t region_access();
    int unsigned        g, s, e;
    logic [PAGE_SHIFT-1:0] lo, hi, tmp;
    logic [ADDR_W-1:0]  first_byte, last_byte;
    g  = $urandom_range(0, REGIONS - 1);
    s  = $urandom_range(0, REGION_PAGES - 1);
    e  = ($urandom_range(0, 1) == 0) ? s : $urandom_range(s, REGION_PAGES - 1);
    lo = PAGE_SHIFT'($urandom());
    hi = PAGE_SHIFT'($urandom());
    if (s == e && hi < lo) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    first_byte = {region_base[g] + PAGE_W'(s), lo};
    last_byte  = {region_base[g] + PAGE_W'(e), hi};
    return record_req(first_byte, SIZE_W'(last_byte - first_byte + 1));
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: holds start until the block takes the request, then
  // leaves start high so a following request can go out back to back
  // ---------------------------------------------------------------------------

  task automatic send_request(input req_t r);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    expected_rsp_q.push_back(predict_table_access(r));
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every strobe must match the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatch_count++;
      end else begin
        expected_rsp = expected_rsp_q.pop_front();
        if (rsp_o.page_count !== expected_rsp.page_count) begin
          $error("page_count: expected %0d, actual %0d",
                 expected_rsp.page_count, rsp_o.page_count);
          mismatch_count++;
        end
        if (rsp_o.lowest_page !== expected_rsp.lowest_page) begin
          $error("lowest_page: expected %0h, actual %0h",
                 expected_rsp.lowest_page, rsp_o.lowest_page);
          mismatch_count++;
        end
        if (rsp_o.highest_page !== expected_rsp.highest_page) begin
          $error("highest_page: expected %0h, actual %0h",
                 expected_rsp.highest_page, rsp_o.highest_page);
          mismatch_count++;
        end
        if (rsp_o.entries_used !== expected_rsp.entries_used) begin
          $error("entries_used: expected %0d, actual %0d",
                 expected_rsp.entries_used, rsp_o.entries_used);
          mismatch_count++;
        end
        if (rsp_o.status !== expected_rsp.status) begin
          $error("status: expected %0d, actual %0d",
                 expected_rsp.status, rsp_o.status);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // queries and zero-length accesses against an empty table
  task automatic test_empty_table();
    send_request(query_req('0));
    send_request(query_req('1));
    send_request(record_req('0, '0));
    send_request(record_req('1, '0));
  endtask

  // single bytes at page edges, exact pages, page crossings, longest access
  task automatic test_field_extremes();
    send_request(record_req('0, SIZE_W'(1)));
    send_request(record_req('0, SIZE_W'(1)));
    send_request(record_req(ADDR_W'(12'hFFF), SIZE_W'(1)));
    send_request(record_req(ADDR_W'(1) << PAGE_SHIFT, SIZE_W'(1) << PAGE_SHIFT));
    send_request(record_req(ADDR_W'(12'hFFF), SIZE_W'(2)));
    send_request(record_req('0, '1));
    send_request(query_req('0));
    send_request(query_req(PAGE_W'(15)));
    send_request(query_req(PAGE_W'(16)));
  endtask

  // accesses at the top of the address space run on into page zero
  task automatic test_page_wrap();
    send_request(record_req('1, SIZE_W'(1)));
    send_request(record_req('1, '1));
    send_request(query_req('1));
    send_request(query_req('0));
  endtask

  // fields that a request kind does not use must not matter
  task automatic test_unused_fields();
    req_t r;
    r = record_req(ADDR_W'(2) << PAGE_SHIFT, SIZE_W'(1));
    r.query_page = '1;
    send_request(r);
    r = query_req(PAGE_W'(2));
    r.address     = '1;
    r.access_size = '1;
    send_request(r);
    r = query_req(PAGE_W'(36'h123456789));
    r.address     = '0;
    r.access_size = '0;
    send_request(r);
  endtask

  // mostly well-formed accesses inside the region pool, plus queries,
  // zero-length accesses and scattered noise
  task automatic test_random_traffic(input int unsigned n_requests);
    int unsigned pick;
    for (int unsigned g = 0; g < REGIONS; g++) begin
      region_base[g] = rand_page() & ~PAGE_W'(15);  // region never wraps
    end
    for (int unsigned i = 0; i < n_requests; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 2;
          default: idle_odds = 5;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_request(region_access());
      end else if (pick < 72) begin
        send_request(query_req(some_tracked_page()));
      end else if (pick < 80) begin
        send_request(query_req(region_base[$urandom_range(0, REGIONS - 1)]
                               + PAGE_W'($urandom_range(0, REGION_PAGES))));
      end else if (pick < 85) begin
        send_request(query_req(rand_page()));
      end else if (pick < 92) begin
        send_request(record_req(rand_address(), '0));
      end else if (tracked_total < NOISE_ROOM) begin
        // at most three pages, so the table cannot fill by accident
        send_request(record_req(rand_address(), SIZE_W'($urandom_range(1, 8192))));
      end else begin
        send_request(region_access());
      end
    end
  endtask

  // brings the table to one free entry, then sends an access over a new
  // page, a second new page and a tracked page: the first takes the last
  // entry, the second is dropped and the tracked one still counts
  task automatic test_fill_table();
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] one_page;
    idle_odds = 4;
    do base = rand_page() & ~PAGE_W'(15);
    while (find_tracked_page(base) >= 0 || find_tracked_page(base + 1) >= 0
           || find_tracked_page(base + 2) >= 0);
    send_request(record_req({base + PAGE_W'(2), PAGE_SHIFT'(0)}, SIZE_W'(1)));
    while (tracked_total < TABLE_ENTRIES - 1) begin
      one_page = fresh_page();
      if (one_page >= base && one_page <= base + 2) continue;
      send_request(record_req({one_page, PAGE_SHIFT'($urandom())}, SIZE_W'(1)));
    end
    send_request(record_req({base, PAGE_SHIFT'(12'h800)}, SIZE_W'(16'h2000)));
    send_request(query_req(base));
    send_request(query_req(base + 1));
    send_request(query_req(base + 2));
    // a full table turns away even pages it already tracks
    send_request(record_req({base + PAGE_W'(2), PAGE_SHIFT'(0)}, SIZE_W'(1)));
    send_request(record_req(rand_address(), '0));
    send_request(query_req(base + 2));
  endtask

  // table full: every access is ignored, queries still answer; no idling
  task automatic test_full_table(input int unsigned n_requests);
    idle_odds = 0;
    for (int unsigned i = 0; i < n_requests; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_request(record_req(rand_address(), SIZE_W'($urandom())));
      end else if ($urandom_range(0, 1) == 0) begin
        send_request(query_req(some_tracked_page()));
      end else begin
        send_request(query_req(rand_page()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tracked_valid[i] = 1'b0;
      tracked_key[i]   = '0;
      tracked_count[i] = '0;
    end
    tracked_total   = 0;
    tracked_lowest  = '0;
    tracked_highest = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_field_extremes();
    test_page_wrap();
    test_unused_fields();
    test_random_traffic(440);
    test_fill_table();
    test_full_table(60);

    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    // catch any stray strobe after the last expected result
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
